### hdl/pzw_pkg.sv
// Shared types and command codes for the cursor pan/zoom/wrap mapper.
// Used by the controller, the datapath and the top level. No dependencies.
package pzw_pkg;

  // fixed limits of the coordinate arithmetic; field widths are sized for these
  localparam int COORD_LIMIT = 4096;
  localparam int WRAP_MARGIN = 100;
  localparam int ZOOM_LIMIT  = 16;

  localparam int OP_W = 4;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_LIM  = 4'd2;
  localparam logic [OP_W-1:0] OP_MAP      = 4'd3;
  localparam logic [OP_W-1:0] OP_MARG     = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_WRAP = 4'd5;
  localparam logic [OP_W-1:0] OP_WFIX     = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_B1   = 4'd7;
  localparam logic [OP_W-1:0] OP_BPAN     = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_B2   = 4'd9;
  localparam logic [OP_W-1:0] OP_BFIX     = 4'd10;
  localparam logic [OP_W-1:0] OP_FINISH   = 4'd11;

  // register indexes of the configuration port
  localparam logic [2:0] REG_PAN_LEFT  = 3'd0;
  localparam logic [2:0] REG_PAN_TOP   = 3'd1;
  localparam logic [2:0] REG_ZOOM      = 3'd2;
  localparam logic [2:0] REG_MEM_W     = 3'd3;
  localparam logic [2:0] REG_MEM_H     = 3'd4;
  localparam logic [2:0] REG_VID_W     = 3'd5;
  localparam logic [2:0] REG_VID_H     = 3'd6;
  localparam logic [2:0] REG_AUTOTRACK = 3'd7;

  localparam int DVD_W = 24;  // divider dividend width
  localparam int DVS_W = 13;  // divider divisor width

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            axis;  // 0: X, 1: Y
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic repos;
  } sts_t;

endpackage

### hdl/pzw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the pzw datapath.
module pzw_div #(
  parameter int DW = 24,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt, dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    sh       = {rem_r, quo_r[DW-1]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(DW);
    end else if (cnt_r != '0) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = VW'(sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hdl/pzw_dp.sv
// Datapath of the mapper: clamps, axis mapping, wrap fix-up and output register.
// Depends on pzw_pkg and pzw_div.
module pzw_dp import pzw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [13:0] sample_x,
  input  logic [13:0] sample_y,
  input  logic [2:0]  button_bits,
  input  logic [12:0] cfg_pan_left,
  input  logic [12:0] cfg_pan_top,
  input  logic [4:0]  cfg_zoom,
  input  logic [12:0] cfg_mem_w,
  input  logic [12:0] cfg_mem_h,
  input  logic [12:0] cfg_vid_w,
  input  logic [12:0] cfg_vid_h,
  input  logic        cfg_autotrack,
  output logic [63:0] out_data
);

  localparam logic [15:0]        CL16    = 16'(COORD_LIMIT);
  localparam logic [7:0]         ZL8     = 8'(ZOOM_LIMIT);
  localparam logic signed [15:0] IN_LO   = -16'sd512;
  localparam logic signed [15:0] IN_HI   = $signed(16'(COORD_LIMIT + 511));
  localparam logic signed [23:0] MARG_LO = -$signed(24'(WRAP_MARGIN + 1));

  function automatic logic [12:0] clamp13(input logic [12:0] v);
    logic [12:0] r;
    if (v == '0) r = 13'd1;
    else if ({3'b0, v} > CL16) r = CL16[12:0];
    else r = v;
    return r;
  endfunction

  function automatic logic [4:0] clamp5(input logic [4:0] v);
    logic [4:0] r;
    if (v == '0) r = 5'd1;
    else if ({3'b0, v} > ZL8) r = ZL8[4:0];
    else r = v;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_in(input logic [13:0] v);
    logic signed [15:0] s;
    logic signed [15:0] r;
    s = $signed({{2{v[13]}}, v});
    if (s < IN_LO) r = IN_LO;
    else if (s > IN_HI) r = IN_HI;
    else r = s;
    return r;
  endfunction

  logic [12:0] pl_r, pt_r, mw_r, mh_r, vw_r, vh_r;
  logic [4:0]  zm_r;
  logic        at_r;
  logic signed [15:0] px_r, py_r;
  logic [2:0]  btn_r;
  logic        set_r, set_nxt;
  logic signed [23:0] prod_r, pm_r;
  logic [17:0] mz_r;
  logic [12:0] sx_r, sy_r, mx_r, my_r;
  logic [13:0] m_r;
  logic [12:0] last_x_r, last_y_r;
  logic [2:0]  last_b_r;
  logic [63:0] out_r;

  // axis selection
  logic [12:0] pan, mem, vid, s_ax;
  logic signed [15:0] p_ax;
  assign pan  = cmd.axis ? pt_r : pl_r;
  assign mem  = cmd.axis ? mh_r : mw_r;
  assign vid  = cmd.axis ? vh_r : vw_r;
  assign p_ax = cmd.axis ? py_r : px_r;
  assign s_ax = cmd.axis ? sy_r : sx_r;

  // shared divider
  logic              div_start, div_done;
  logic [DVD_W-1:0]  dvd, quo;
  logic [DVS_W-1:0]  dvs, rem;
  logic [23:0]       pm_abs;

  assign pm_abs = pm_r[23] ? 24'(-pm_r) : 24'(pm_r);

  always_comb begin
    div_start = 1'b1;
    dvd       = '0;
    dvs       = 13'd1;
    unique case (cmd.op)
      OP_DIV_LIM: begin
        dvd = 24'(vid) + 24'(zm_r) - 24'd1;
        dvs = 13'(zm_r);
      end
      OP_DIV_WRAP: begin
        dvd = pm_abs;
        dvs = vid;
      end
      OP_DIV_B1: begin
        dvd = 24'(s_ax) - 24'd1;
        dvs = 13'(zm_r);
      end
      OP_DIV_B2: begin
        dvd = 24'(m_r) - 24'd1;
        dvs = mem;
      end
      default: div_start = 1'b0;
    endcase
  end

  pzw_div #(.DW(DVD_W), .VW(DVS_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // axis mapping: window test, memory wrap, scale
  logic signed [17:0] p18, pan18, mem18, vid18, lim18, pa;
  logic               outside;
  logic signed [23:0] prod_c;
  logic [17:0]        mz_c;

  always_comb begin
    p18     = {{2{p_ax[15]}}, p_ax};
    pan18   = $signed({5'b0, pan});
    mem18   = $signed({5'b0, mem});
    vid18   = $signed({5'b0, vid});
    lim18   = pan18 + $signed({4'b0, quo[13:0]});
    set_nxt = set_r;
    if (lim18 > mem18) outside = (p18 < pan18) && (p18 >= lim18 - mem18);
    else outside = (p18 < pan18) || (p18 >= lim18);
    pa = p18;
    if (outside) begin
      set_nxt = 1'b1;
      if (pa < 18'sd1) pa = pa + vid18;
      if (pa > mem18) pa = pa - vid18;
    end else begin
      if (pa < 18'sd1) begin
        pa      = pa + mem18;
        set_nxt = 1'b1;
      end
      if (pa > mem18) begin
        pa      = pa - mem18;
        set_nxt = 1'b1;
      end
    end
    prod_c = (pa - pan18) * $signed({1'b0, zm_r});
    mz_c   = 18'(mem) * 18'(zm_r);
  end

  // screen wrap fix-up, with a correction for a negative dividend
  logic [12:0] s_new;
  assign s_new = ((pm_r[23] && rem != '0) ? (vid - rem) : rem) + 13'd1;

  logic changed, repos, publish;
  assign repos   = set_r & at_r;
  assign changed = (sx_r != last_x_r) || (sy_r != last_y_r) || (btn_r != last_b_r) || set_r;
  assign publish = changed & at_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= 13'd1;
      last_y_r <= 13'd2;
      last_b_r <= 3'd3;
    end else if (cmd.op == OP_FINISH && publish) begin
      last_x_r <= sx_r;
      last_y_r <= sy_r;
      last_b_r <= btn_r;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        pl_r  <= clamp13(cfg_pan_left);
        pt_r  <= clamp13(cfg_pan_top);
        mw_r  <= clamp13(cfg_mem_w);
        mh_r  <= clamp13(cfg_mem_h);
        vw_r  <= clamp13(cfg_vid_w);
        vh_r  <= clamp13(cfg_vid_h);
        zm_r  <= clamp5(cfg_zoom);
        at_r  <= cfg_autotrack;
        px_r  <= clamp_in(sample_x);
        py_r  <= clamp_in(sample_y);
        btn_r <= button_bits;
        set_r <= 1'b0;
        mx_r  <= '0;
        my_r  <= '0;
      end
      OP_MAP: begin
        set_r  <= set_nxt;
        prod_r <= prod_c;
        mz_r   <= mz_c;
      end
      OP_MARG: pm_r <= (prod_r < MARG_LO) ? prod_r + $signed({6'b0, mz_r}) : prod_r;
      OP_WFIX: begin
        if (cmd.axis) sy_r <= s_new;
        else sx_r <= s_new;
      end
      OP_BPAN: m_r <= quo[13:0] + {1'b0, pan};
      OP_BFIX: begin
        if (cmd.axis) my_r <= rem + 13'd1;
        else mx_r <= rem + 13'd1;
      end
      OP_FINISH: out_r <= {6'b0, my_r, mx_r, publish, repos, changed, btn_r, sy_r, sx_r};
      default: ;
    endcase
  end

  assign sts.div_done = div_done;
  assign sts.repos    = repos;
  assign out_data     = out_r;

endmodule

### hdl/pzw_ctrl.sv
// Sequencer of the mapper: steps the datapath through both axes and the
// optional map-back, and owns the stream handshakes. Depends on pzw_pkg.
module pzw_ctrl import pzw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LIM    = 4'd1;
  localparam logic [3:0] S_LIM_W  = 4'd2;
  localparam logic [3:0] S_MAP    = 4'd3;
  localparam logic [3:0] S_MARG   = 4'd4;
  localparam logic [3:0] S_WRAP   = 4'd5;
  localparam logic [3:0] S_WRAP_W = 4'd6;
  localparam logic [3:0] S_WFIX   = 4'd7;
  localparam logic [3:0] S_B1     = 4'd8;
  localparam logic [3:0] S_B1_W   = 4'd9;
  localparam logic [3:0] S_BPAN   = 4'd10;
  localparam logic [3:0] S_B2     = 4'd11;
  localparam logic [3:0] S_B2_W   = 4'd12;
  localparam logic [3:0] S_BFIX   = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       axis_r, axis_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    ov_nxt    = ov_r & ~out_tready;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          axis_nxt  = 1'b0;
          state_nxt = S_LIM;
        end
      end
      S_LIM: begin
        cmd.op    = OP_DIV_LIM;
        state_nxt = S_LIM_W;
      end
      S_LIM_W: if (sts.div_done) state_nxt = S_MAP;
      S_MAP: begin
        cmd.op    = OP_MAP;
        state_nxt = S_MARG;
      end
      S_MARG: begin
        cmd.op    = OP_MARG;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        cmd.op    = OP_DIV_WRAP;
        state_nxt = S_WRAP_W;
      end
      S_WRAP_W: if (sts.div_done) state_nxt = S_WFIX;
      S_WFIX: begin
        cmd.op = OP_WFIX;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_LIM;
        end else if (sts.repos) begin
          axis_nxt  = 1'b0;
          state_nxt = S_B1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_B1: begin
        cmd.op    = OP_DIV_B1;
        state_nxt = S_B1_W;
      end
      S_B1_W: if (sts.div_done) state_nxt = S_BPAN;
      S_BPAN: begin
        cmd.op    = OP_BPAN;
        state_nxt = S_B2;
      end
      S_B2: begin
        cmd.op    = OP_DIV_B2;
        state_nxt = S_B2_W;
      end
      S_B2_W: if (sts.div_done) state_nxt = S_BFIX;
      S_BFIX: begin
        cmd.op = OP_BFIX;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_B1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          cmd.op    = OP_FINISH;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;

endmodule

### hdl/cursor_pan_zoom_wrap_mapper.sv
// Top level of the cursor pan/zoom/wrap mapper: APB register file, sequencer
// and datapath. Depends on pzw_pkg, pzw_ctrl, pzw_dp (and pzw_div below it).
//
// Takes one mouse sample per item (X, Y in image-memory coordinates, buttons)
// and returns one item: the screen position after memory wrap, pan, zoom and
// video wrap, the buttons, the changed / reposition / publish flags, and when
// a reposition is due the position mapped back into image memory (else 0).
// Registers are sampled when an item is accepted and clamped to their ranges.
// One item at a time: a new sample is taken only once the last one has been
// passed to the output register. All divisions run on one shared 24-bit
// restoring divider: four per item, or eight when a reposition forces the
// map-back. A finished item waits in the output register while the next
// sample is already being taken in.
module cursor_pan_zoom_wrap_mapper import pzw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [13:0] sample_x, [27:14] sample_y, [30:28] button_bits, [31] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out_tdata: [12:0] screen_x, [25:13] screen_y, [28:26] button_state,
  // [29] changed, [30] reposition, [31] publish, [44:32] memory_x,
  // [57:45] memory_y, [63:58] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [12:0] pan_left_r, pan_top_r, mem_w_r, mem_h_r, vid_w_r, vid_h_r;
  logic [4:0]  zoom_r;
  logic        autotrack_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_left_r  <= 13'd1;
      pan_top_r   <= 13'd1;
      zoom_r      <= 5'd1;
      mem_w_r     <= 13'd1024;
      mem_h_r     <= 13'd1024;
      vid_w_r     <= 13'd1024;
      vid_h_r     <= 13'd1024;
      autotrack_r <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAN_LEFT:  pan_left_r  <= cfg_pwdata[12:0];
        REG_PAN_TOP:   pan_top_r   <= cfg_pwdata[12:0];
        REG_ZOOM:      zoom_r      <= cfg_pwdata[4:0];
        REG_MEM_W:     mem_w_r     <= cfg_pwdata[12:0];
        REG_MEM_H:     mem_h_r     <= cfg_pwdata[12:0];
        REG_VID_W:     vid_w_r     <= cfg_pwdata[12:0];
        REG_VID_H:     vid_h_r     <= cfg_pwdata[12:0];
        REG_AUTOTRACK: autotrack_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAN_LEFT:  cfg_prdata = {19'b0, pan_left_r};
      REG_PAN_TOP:   cfg_prdata = {19'b0, pan_top_r};
      REG_ZOOM:      cfg_prdata = {27'b0, zoom_r};
      REG_MEM_W:     cfg_prdata = {19'b0, mem_w_r};
      REG_MEM_H:     cfg_prdata = {19'b0, mem_h_r};
      REG_VID_W:     cfg_prdata = {19'b0, vid_w_r};
      REG_VID_H:     cfg_prdata = {19'b0, vid_h_r};
      REG_AUTOTRACK: cfg_prdata = {31'b0, autotrack_r};
      default:       cfg_prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  pzw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pzw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .sample_x      (in_tdata[13:0]),
    .sample_y      (in_tdata[27:14]),
    .button_bits   (in_tdata[30:28]),
    .cfg_pan_left  (pan_left_r),
    .cfg_pan_top   (pan_top_r),
    .cfg_zoom      (zoom_r),
    .cfg_mem_w     (mem_w_r),
    .cfg_mem_h     (mem_h_r),
    .cfg_vid_w     (vid_w_r),
    .cfg_vid_h     (vid_h_r),
    .cfg_autotrack (autotrack_r),
    .out_data      (out_tdata)
  );

endmodule
